[rtl/gjcm_pkg.sv]
// shared types and constants for the greedy jet cone matcher
// no dependencies; used by greedy_jet_cone_matcher

package gjcm_pkg;

   // table depth default
   localparam int MAX_REFS_DEFAULT = 64;

   // field widths
   localparam int ETA_W  = 16;
   localparam int PHI_W  = 15;
   localparam int PT_W   = 24;
   localparam int DIST_W = 31;
   localparam int IDX_OUT_W = 7;

   // packed reference entry: eta low, then phi, then pt
   localparam int REF_W = ETA_W + PHI_W + PT_W;

   // angle constants, 2^-12 rad units, sized for the 17-bit phi difference
   localparam logic signed [16:0] PI_FX     = 17'sd12868;
   localparam logic signed [16:0] TWO_PI_FX = 17'sd25736;

   // saturation value for squared distances
   localparam logic [DIST_W-1:0] DIST_SAT = {DIST_W{1'b1}};

   // register reset values, 2^-24 units
   localparam logic [DIST_W-1:0] MATCH_RADIUS_RESET  = 31'd1509949;
   localparam logic [DIST_W-1:0] PILEUP_RADIUS_RESET = 31'd6039798;

   // index reported when nothing matched
   localparam logic [IDX_OUT_W-1:0] NO_MATCH = {IDX_OUT_W{1'b1}};

   // configuration register indexes
   localparam logic [1:0] REG_MATCH_RADIUS  = 2'd0;
   localparam logic [1:0] REG_PILEUP_RADIUS = 2'd1;

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_LOAD  = 2'd1,
      OP_MATCH = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

endpackage

[rtl/gjcm_ram.sv]
// generic single-port-write, single-port-read ram with registered read data
// no dependencies

module gjcm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/greedy_jet_cone_matcher.sv]
// greedy delta-r jet matcher: reference table, scan pipeline and result register
// depends on gjcm_pkg and gjcm_ram
//
// timing: clear, load and no-op items go from ST_IDLE to ST_FINISH, which registers the result;
//   a match item passes ST_SCAN, where each table entry runs through stages a to d, then ST_FINISH
// req_tready is low outside ST_IDLE, so no new item is taken until the last result is registered;
//   a match scan uses the single distance pipeline, reading one table entry per cycle,
//   and a result held by rsp_tready stalls ST_FINISH and with it the next item
// reset: synchronous, empties the table and matched marks, radii to their defaults

module greedy_jet_cone_matcher #(
   parameter int MAX_REFS = gjcm_pkg::MAX_REFS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,

   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // jet_eta[15:0], jet_phi[30:16], jet_pt[54:31], zero
   input  logic [1:0]  req_tuser,   // operation[1:0]

   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // match_index[6:0], is_pileup[7], nearest_dist_sq[38:8], zero
   output logic        rsp_tuser,   // status[0]

   // register write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [30:0] csr_data
);

   localparam int IDX_W = (MAX_REFS > 1) ? $clog2(MAX_REFS) : 1;
   localparam int CNT_W = $clog2(MAX_REFS + 1);
   localparam int ETA_W = gjcm_pkg::ETA_W;
   localparam int PHI_W = gjcm_pkg::PHI_W;
   localparam int PT_W  = gjcm_pkg::PT_W;
   localparam int DIST_W = gjcm_pkg::DIST_W;
   localparam int REF_W = gjcm_pkg::REF_W;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   // control state
   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    scan_idx_ff, scan_idx_in;
   logic [MAX_REFS-1:0] taken_ff, taken_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [DIST_W-1:0]   match_radius_ff, match_radius_in;
   logic [DIST_W-1:0]   pileup_radius_ff, pileup_radius_in;
   logic                have_ff, have_in;

   // scan pipeline valids
   logic                v_a_ff, v_b_ff, v_c_ff, v_d_ff;
   logic                issue;

   // latched item
   gjcm_pkg::op_type    op_ff;
   logic signed [ETA_W-1:0] eta_ff;
   logic signed [PHI_W-1:0] phi_ff;
   logic                status_ff;

   // running best
   logic [DIST_W-1:0]   best_d_ff, best_d_in;
   logic [PT_W-1:0]     best_pt_ff, best_pt_in;
   logic [IDX_W-1:0]    best_i_ff, best_i_in;

   // pipeline payload
   logic [IDX_W-1:0]    idx_a_ff, idx_b_ff, idx_c_ff, idx_d_ff;
   logic signed [16:0]  de_ff;
   logic signed [15:0]  dp_ff;
   logic [PT_W-1:0]     pt_b_ff, pt_c_ff, pt_d_ff;
   logic [32:0]         sq_e_ff;
   logic [27:0]         sq_p_ff;
   logic [DIST_W-1:0]   dist_d_ff;

   // output payload
   logic [39:0]         rsp_data_ff, rsp_data_in;
   logic                rsp_user_ff, rsp_user_in;

   // ram
   logic                ram_wr_en;
   logic [REF_W-1:0]    ram_rd_data;
   logic [REF_W-1:0]    ram_wr_data;

   // stage b arithmetic
   logic signed [ETA_W-1:0] ref_eta;
   logic signed [PHI_W-1:0] ref_phi;
   logic signed [16:0]  de_comb;
   logic signed [16:0]  dp_raw;
   logic signed [16:0]  dp_wrap;
   logic signed [33:0]  sq_e_full;
   logic signed [31:0]  sq_p_full;
   logic [33:0]         dist_sum;

   // result formatting
   logic [IDX_W+6:0]    best_i_ext;
   logic [6:0]          match_idx;
   logic                pileup;

   gjcm_pkg::op_type    req_op;
   logic                req_accept;
   logic                out_free;
   logic                table_full;

   assign req_op     = gjcm_pkg::op_type'(req_tuser);
   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = (state_ff == ST_IDLE);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign table_full = (count_ff >= CNT_W'(MAX_REFS));
   assign issue      = (state_ff == ST_SCAN) && (scan_idx_ff < count_ff);

   // load writes at accept, scan reads only in ST_SCAN, so the ports never collide
   assign ram_wr_en   = req_accept && (req_op == gjcm_pkg::OP_LOAD) && !table_full;
   assign ram_wr_data = req_tdata[REF_W-1:0];

   gjcm_ram #(
      .WIDTH (REF_W),
      .DEPTH (MAX_REFS)
   ) u_ref_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (ram_wr_data),
      .rd_addr (scan_idx_ff[IDX_W-1:0]),
      .rd_data (ram_rd_data)
   );

   // stage b: eta difference and phi difference wrapped into [-pi, pi]
   // one whole turn is always enough for 15-bit phi inputs
   always_comb begin
      ref_eta = ram_rd_data[ETA_W-1:0];
      ref_phi = ram_rd_data[ETA_W+PHI_W-1:ETA_W];
      de_comb = {eta_ff[ETA_W-1], eta_ff} - {ref_eta[ETA_W-1], ref_eta};
      dp_raw  = {{2{phi_ff[PHI_W-1]}}, phi_ff} - {{2{ref_phi[PHI_W-1]}}, ref_phi};
      if (dp_raw > gjcm_pkg::PI_FX) begin
         dp_wrap = dp_raw - gjcm_pkg::TWO_PI_FX;
      end else if (dp_raw < -gjcm_pkg::PI_FX) begin
         dp_wrap = dp_raw + gjcm_pkg::TWO_PI_FX;
      end else begin
         dp_wrap = dp_raw;
      end
   end

   // stage c: squares; stage d: sum with saturation
   assign sq_e_full = de_ff * de_ff;
   assign sq_p_full = dp_ff * dp_ff;
   assign dist_sum  = {1'b0, sq_e_ff} + {6'd0, sq_p_ff};

   // result fields
   assign best_i_ext = {7'd0, best_i_ff};
   assign match_idx  = have_ff ? best_i_ext[6:0] : gjcm_pkg::NO_MATCH;
   assign pileup     = (count_ff == '0) || (best_d_ff > pileup_radius_ff);

   always_comb begin
      state_in         = state_ff;
      count_in         = count_ff;
      scan_idx_in      = scan_idx_ff;
      taken_in         = taken_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_tready;
      match_radius_in  = match_radius_ff;
      pileup_radius_in = pileup_radius_ff;
      have_in          = have_ff;
      best_d_in        = best_d_ff;
      best_pt_in       = best_pt_ff;
      best_i_in        = best_i_ff;
      rsp_data_in      = rsp_data_ff;
      rsp_user_in      = rsp_user_ff;

      // register writes, taken while idle
      if (csr_valid && csr_ready) begin
         case (csr_index)
            gjcm_pkg::REG_MATCH_RADIUS:  match_radius_in  = csr_data;
            gjcm_pkg::REG_PILEUP_RADIUS: pileup_radius_in = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_FINISH;
               case (req_op)
                  gjcm_pkg::OP_CLEAR: begin
                     count_in = '0;
                     taken_in = '0;
                  end
                  gjcm_pkg::OP_LOAD: begin
                     if (!table_full) begin
                        count_in = count_ff + 1'b1;
                        taken_in[count_ff[IDX_W-1:0]] = 1'b0;
                     end
                  end
                  gjcm_pkg::OP_MATCH: begin
                     state_in    = ST_SCAN;
                     scan_idx_in = '0;
                     have_in     = 1'b0;
                     best_d_in   = gjcm_pkg::DIST_SAT;
                     best_pt_in  = '0;
                     best_i_in   = '0;
                  end
                  default: ;
               endcase
            end
         end

         ST_SCAN: begin
            if (issue) begin
               scan_idx_in = scan_idx_ff + 1'b1;
            end
            // update stage: nearest distance over all entries, best pt over free ones inside the match radius
            if (v_d_ff) begin
               if (dist_d_ff < best_d_ff) begin
                  best_d_in = dist_d_ff;
               end
               if (!taken_ff[idx_d_ff] && (dist_d_ff < match_radius_ff) &&
                   (!have_ff || (pt_d_ff > best_pt_ff))) begin
                  have_in    = 1'b1;
                  best_pt_in = pt_d_ff;
                  best_i_in  = idx_d_ff;
               end
            end
            if (!issue && !v_a_ff && !v_b_ff && !v_c_ff && !v_d_ff) begin
               state_in = ST_FINISH;
            end
         end

         ST_FINISH: begin
            if (out_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_user_in  = status_ff;
               if (op_ff == gjcm_pkg::OP_MATCH) begin
                  rsp_data_in = {1'b0, best_d_ff, pileup, match_idx};
                  if (have_ff) begin
                     taken_in[best_i_ff] = 1'b1;
                  end
               end else begin
                  rsp_data_in = {1'b0, {DIST_W{1'b0}}, 1'b0, gjcm_pkg::NO_MATCH};
               end
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         count_ff         <= '0;
         scan_idx_ff      <= '0;
         taken_ff         <= '0;
         rsp_valid_ff     <= 1'b0;
         match_radius_ff  <= gjcm_pkg::MATCH_RADIUS_RESET;
         pileup_radius_ff <= gjcm_pkg::PILEUP_RADIUS_RESET;
         have_ff          <= 1'b0;
         v_a_ff           <= 1'b0;
         v_b_ff           <= 1'b0;
         v_c_ff           <= 1'b0;
         v_d_ff           <= 1'b0;
      end else begin
         state_ff         <= state_in;
         count_ff         <= count_in;
         scan_idx_ff      <= scan_idx_in;
         taken_ff         <= taken_in;
         rsp_valid_ff     <= rsp_valid_in;
         match_radius_ff  <= match_radius_in;
         pileup_radius_ff <= pileup_radius_in;
         have_ff          <= have_in;
         v_a_ff           <= issue;
         v_b_ff           <= v_a_ff;
         v_c_ff           <= v_b_ff;
         v_d_ff           <= v_c_ff;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff     <= req_op;
         eta_ff    <= req_tdata[ETA_W-1:0];
         phi_ff    <= req_tdata[ETA_W+PHI_W-1:ETA_W];
         status_ff <= (req_op == gjcm_pkg::OP_LOAD) && table_full;
      end
      best_d_ff   <= best_d_in;
      best_pt_ff  <= best_pt_in;
      best_i_ff   <= best_i_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;

      // stage a: ram read in flight
      idx_a_ff  <= scan_idx_ff[IDX_W-1:0];
      // stage b: differences
      idx_b_ff  <= idx_a_ff;
      de_ff     <= de_comb;
      dp_ff     <= dp_wrap[15:0];
      pt_b_ff   <= ram_rd_data[REF_W-1:ETA_W+PHI_W];
      // stage c: squares
      idx_c_ff  <= idx_b_ff;
      pt_c_ff   <= pt_b_ff;
      sq_e_ff   <= sq_e_full[32:0];
      sq_p_ff   <= sq_p_full[27:0];
      // stage d: saturated distance
      idx_d_ff  <= idx_c_ff;
      pt_d_ff   <= pt_c_ff;
      dist_d_ff <= (dist_sum > {3'd0, gjcm_pkg::DIST_SAT}) ? gjcm_pkg::DIST_SAT
                                                          : dist_sum[DIST_W-1:0];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

[test/tb_top.sv]
// self-checking testbench for greedy_jet_cone_matcher: directed and random event streams
// depends on gjcm_pkg and the rtl of the block; a built-in predictor supplies expected results

module tb_top;
   import gjcm_pkg::*;

   localparam int TABLE_DEPTH = MAX_REFS_DEFAULT;

   // one request transaction as the driver sees it
   typedef struct {
      op_type                  op;
      logic signed [ETA_W-1:0] eta;
      logic signed [PHI_W-1:0] phi;
      logic [PT_W-1:0]         pt;
   } jet_item_type;

   // one response transaction, field by field
   typedef struct {
      logic                 status;
      logic [IDX_OUT_W-1:0] index;
      logic                 pileup;
      logic [DIST_W-1:0]    near_d;
   } jet_outcome_type;

   // clock, reset and every block input start at known values
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;   // jet_eta[15:0], jet_phi[30:16], jet_pt[54:31], zero
   logic [1:0]  req_tuser = '0;   // operation[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // match_index[6:0], is_pileup[7], nearest_dist_sq[38:8], zero
   logic        rsp_tuser;        // status[0]
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [30:0] csr_data = '0;

   greedy_jet_cone_matcher u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #2_000_000;
      $display("greedy_jet_cone_matcher: mismatch");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // predictor state: reference table, matched marks and the two radii
   // ---------------------------------------------------------------------------
   logic signed [ETA_W-1:0] table_eta [TABLE_DEPTH];
   logic signed [PHI_W-1:0] table_phi [TABLE_DEPTH];
   logic [PT_W-1:0]         table_pt  [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0]  table_taken = '0;
   int                      table_count = 0;
   logic [DIST_W-1:0]       match_radius  = MATCH_RADIUS_RESET;
   logic [DIST_W-1:0]       pileup_radius = PILEUP_RADIUS_RESET;

   jet_item_type    jet_queue[$];          // items waiting for the driver
   jet_outcome_type predicted_outcomes[$]; // results owed by the block, oldest first
   jet_item_type    driven_item;           // item currently on the request bus
   int              mismatch_count = 0;

   // squared eta-phi distance, phi difference wrapped by whole turns into [-pi, pi]
   function automatic logic [DIST_W-1:0] cone_dist_sq(
      input logic signed [ETA_W-1:0] eta_a, input logic signed [PHI_W-1:0] phi_a,
      input logic signed [ETA_W-1:0] eta_b, input logic signed [PHI_W-1:0] phi_b);
      longint d_eta, d_phi, sum;
      d_eta = longint'(eta_a) - longint'(eta_b);
      d_phi = longint'(phi_a) - longint'(phi_b);
      while (d_phi > longint'(PI_FX)) d_phi -= longint'(TWO_PI_FX);
      while (d_phi < -longint'(PI_FX)) d_phi += longint'(TWO_PI_FX);
      sum = d_eta * d_eta + d_phi * d_phi;
      if (sum > longint'(DIST_SAT)) return DIST_SAT;
      return sum[DIST_W-1:0];
   endfunction

   // advance the table by one accepted item and return the result it owes
   function automatic jet_outcome_type apply_jet_item(input jet_item_type it);
      jet_outcome_type   r;
      logic [DIST_W-1:0] d, best_d;
      logic [PT_W-1:0]   best_pt;
      int                best_i;
      bit                found;
      r.status = 1'b0;
      r.index  = NO_MATCH;
      r.pileup = 1'b0;
      r.near_d = '0;
      case (it.op)
         OP_CLEAR: begin
            table_count = 0;
            table_taken = '0;
         end
         OP_LOAD: begin
            if (table_count < TABLE_DEPTH) begin
               table_eta[table_count]   = it.eta;
               table_phi[table_count]   = it.phi;
               table_pt[table_count]    = it.pt;
               table_taken[table_count] = 1'b0;
               table_count++;
            end else begin
               r.status = 1'b1;   // table full, jet dropped
            end
         end
         OP_MATCH: begin
            best_d  = DIST_SAT;
            best_pt = '0;
            best_i  = 0;
            found   = 1'b0;
            for (int i = 0; i < table_count; i++) begin
               d = cone_dist_sq(it.eta, it.phi, table_eta[i], table_phi[i]);
               // taken references still count for the nearest distance
               if (d < best_d) best_d = d;
               // strict pt compare keeps the lower index on a tie
               if (!table_taken[i] && d < match_radius && (!found || table_pt[i] > best_pt)) begin
                  found   = 1'b1;
                  best_pt = table_pt[i];
                  best_i  = i;
               end
            end
            if (found) begin
               table_taken[best_i] = 1'b1;
               r.index = best_i[IDX_OUT_W-1:0];
            end
            r.near_d = best_d;
            r.pileup = (table_count == 0) || (best_d > pileup_radius);
         end
         default: ;   // no-op: clear-shaped result, state untouched
      endcase
      return r;
   endfunction

   // ---------------------------------------------------------------------------
   // driver: one item per transaction, random idle gap drawn per item
   // ---------------------------------------------------------------------------
   int req_gap = 0;
   bit req_steady = 1'b0;   // stretches with no idling on the request side

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap = 0;
      end else begin
         // prediction happens at the accepting edge, in request order
         if (req_tvalid && req_tready)
            predicted_outcomes.insert(predicted_outcomes.size(), apply_jet_item(driven_item));
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (jet_queue.size() > 0) begin
               driven_item = jet_queue.pop_front();
               req_tdata  <= {1'b0, driven_item.pt, driven_item.phi, driven_item.eta};
               req_tuser  <= driven_item.op;
               req_tvalid <= 1'b1;
               if ($urandom_range(0, 63) == 0) req_steady = !req_steady;
               req_gap = req_steady ? 0 : $urandom_range(0, 11);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // monitor: random back-pressure per result, field-by-field compare
   // ---------------------------------------------------------------------------
   int rsp_stall = 0;
   bit rsp_steady = 1'b0;   // stretches with no stalls on the response side

   always @(posedge clock) begin : monitor
      jet_outcome_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (predicted_outcomes.size() == 0) begin
               $display("%0t: unexpected result: expected none, actual index %0d status %0d",
                        $time, rsp_tdata[6:0], rsp_tuser);
               mismatch_count++;
            end else begin
               want = predicted_outcomes.pop_front();
               if (rsp_tuser !== want.status) begin
                  $display("%0t: status expected %0d actual %0d", $time, want.status, rsp_tuser);
                  mismatch_count++;
               end
               if (rsp_tdata[6:0] !== want.index) begin
                  $display("%0t: match_index expected 0x%0h actual 0x%0h",
                           $time, want.index, rsp_tdata[6:0]);
                  mismatch_count++;
               end
               if (rsp_tdata[7] !== want.pileup) begin
                  $display("%0t: is_pileup expected %0d actual %0d",
                           $time, want.pileup, rsp_tdata[7]);
                  mismatch_count++;
               end
               if (rsp_tdata[38:8] !== want.near_d) begin
                  $display("%0t: nearest_dist_sq expected %0d actual %0d",
                           $time, want.near_d, rsp_tdata[38:8]);
                  mismatch_count++;
               end
            end
            if ($urandom_range(0, 63) == 0) rsp_steady = !rsp_steady;
            rsp_stall = rsp_steady ? 0 : $urandom_range(0, 11);
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------------
   task automatic queue_jet(input op_type op, input int eta, input int phi,
                            input logic [31:0] pt);
      jet_item_type it;
      it.op  = op;
      it.eta = eta[ETA_W-1:0];
      it.phi = phi[PHI_W-1:0];
      it.pt  = pt[PT_W-1:0];
      jet_queue.insert(jet_queue.size(), it);
   endtask

   // mostly physical eta, sometimes any 16-bit pattern
   function automatic int rand_eta();
      if ($urandom_range(0, 7) == 0) return int'($urandom_range(0, 65535)) - 32768;
      return int'($urandom_range(0, 40960)) - 20480;
   endfunction

   // mostly within [-pi, pi], sometimes any 15-bit pattern
   function automatic int rand_phi();
      if ($urandom_range(0, 7) == 0) return int'($urandom_range(0, 32767)) - 16384;
      return int'($urandom_range(0, 25736)) - 12868;
   endfunction

   // radius on a rough log scale so tiny and huge cones both show up
   function automatic logic [DIST_W-1:0] rand_radius();
      logic [31:0] raw;
      raw = $urandom >> $urandom_range(1, 24);
      return raw[DIST_W-1:0];
   endfunction

   // point at a small, medium or wide offset from a reference, phi kept on the circle
   task automatic near_point(input int eta, input int phi, output int eta_o, output int phi_o);
      int spread;
      spread = ($urandom_range(0, 2) == 0) ? 64 : (($urandom_range(0, 1) == 0) ? 1400 : 5000);
      eta_o = eta + int'($urandom_range(0, 2 * spread)) - spread;
      phi_o = phi + int'($urandom_range(0, 2 * spread)) - spread;
      if (phi_o > 12868) phi_o -= 25736;
      else if (phi_o < -12868) phi_o += 25736;
   endtask

   // random events: clear, pt-sorted loads, then matches near the loaded jets
   task automatic queue_random_phase(input int target);
      int made, n_refs, n_jets, pick, eta_v, phi_v, pt_v;
      int ref_eta_list[$];
      int ref_phi_list[$];
      made = 0;
      while (made < target) begin
         ref_eta_list.delete();
         ref_phi_list.delete();
         // now and then skip the clear to keep stale marks and push the table to overflow
         if ($urandom_range(0, 9) != 0) begin
            queue_jet(OP_CLEAR, rand_eta(), rand_phi(), $urandom);
            made++;
         end
         // mostly small tables, a few that reach past full
         n_refs = ($urandom_range(0, 15) == 0) ? $urandom_range(56, 70) : $urandom_range(0, 10);
         pt_v   = ($urandom_range(0, 3) == 0) ? 32'hFF_FFFF : $urandom_range(0, 32'hFF_FFFF);
         for (int k = 0; k < n_refs; k++) begin
            if (ref_eta_list.size() > 0 && $urandom_range(0, 3) == 0)
               near_point(ref_eta_list[$], ref_phi_list[$], eta_v, phi_v);
            else begin
               eta_v = rand_eta();
               phi_v = rand_phi();
            end
            // descending pt with repeats; rarely out of order
            queue_jet(OP_LOAD, eta_v, phi_v, ($urandom_range(0, 11) == 0) ? $urandom : pt_v);
            ref_eta_list.insert(ref_eta_list.size(), eta_v);
            ref_phi_list.insert(ref_phi_list.size(), phi_v);
            made++;
            if ($urandom_range(0, 2) != 0) begin
               pt_v = pt_v - int'($urandom_range(0, 300000));
               if (pt_v < 0) pt_v = 0;
            end
         end
         n_jets = $urandom_range(1, n_refs + 3);
         for (int k = 0; k < n_jets; k++) begin
            if (ref_eta_list.size() > 0 && $urandom_range(0, 3) != 0) begin
               pick = $urandom_range(0, ref_eta_list.size() - 1);
               near_point(ref_eta_list[pick], ref_phi_list[pick], eta_v, phi_v);
            end else begin
               eta_v = rand_eta();
               phi_v = rand_phi();
            end
            queue_jet(OP_MATCH, eta_v, phi_v, $urandom);
            made++;
            // noise: stray no-ops (not counted) and late loads
            case ($urandom_range(0, 24))
               0: queue_jet(OP_NOP, rand_eta(), rand_phi(), $urandom);
               1: begin
                  queue_jet(OP_LOAD, rand_eta(), rand_phi(), $urandom);
                  made++;
               end
               default: ;
            endcase
         end
      end
   endtask

   // block is idle once nothing waits, nothing is on the bus and nothing is owed
   task automatic wait_drained();
      do @(negedge clock);
      while (jet_queue.size() != 0 || req_tvalid || predicted_outcomes.size() != 0);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [DIST_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == REG_MATCH_RADIUS) match_radius = value;
      else pileup_radius = value;
   endtask

   // ---------------------------------------------------------------------------
   // test sequence
   // ---------------------------------------------------------------------------
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: empty table, no-op, field extremes, phi wrap, saturation
      queue_jet(OP_MATCH, 0, 0, 0);                 // empty table: saturated, pileup
      queue_jet(OP_NOP, -1, -1, 32'hFF_FFFF);
      queue_jet(OP_LOAD, 0, 0, 32'hFF_FFFF);        // index 0
      queue_jet(OP_LOAD, 32767, 16383, 5000);       // index 1, top of both fields
      queue_jet(OP_LOAD, -32768, -16384, 5000);     // index 2, bottom of both fields
      queue_jet(OP_LOAD, 100, 12800, 5000);         // index 3, just below pi
      queue_jet(OP_LOAD, 100, -12800, 0);           // index 4, just above -pi, zero pt
      queue_jet(OP_MATCH, 0, 0, 0);                 // exact hit on index 0
      queue_jet(OP_MATCH, 0, 0, 0);                 // index 0 already taken
      queue_jet(OP_MATCH, 100, -12860, 0);          // across the wrap: higher pt wins
      queue_jet(OP_MATCH, 100, -12860, 0);          // then the zero-pt one
      queue_jet(OP_MATCH, 32767, 16383, 0);         // far corner, out-of-range phi wrap
      queue_jet(OP_MATCH, -32768, -16384, 0);       // opposite corner, saturated distances
      queue_jet(OP_CLEAR, 0, 0, 0);
      queue_jet(OP_LOAD, 0, 0, 777);                // equal pt pair at one spot
      queue_jet(OP_LOAD, 0, 0, 777);
      queue_jet(OP_MATCH, 10, 10, 0);               // lower index wins the tie
      queue_jet(OP_MATCH, 10, 10, 0);
      queue_jet(OP_MATCH, 10, 10, 0);               // both taken
      queue_jet(OP_NOP, 0, 0, 0);
      wait_drained();

      // directed: distance right on both radii
      write_reg(REG_MATCH_RADIUS, 31'd1000000);
      write_reg(REG_PILEUP_RADIUS, 31'd1000000);
      queue_jet(OP_CLEAR, 0, 0, 0);
      queue_jet(OP_LOAD, 0, 0, 1);
      queue_jet(OP_MATCH, 1000, 0, 0);              // equal to both: no match, no pileup
      queue_jet(OP_MATCH, 1001, 0, 0);              // just outside both
      queue_jet(OP_MATCH, 999, 0, 0);               // just inside both

      // random phases, each under its own radius setting
      for (int ph = 0; ph < 6; ph++) begin
         wait_drained();
         case (ph)
            0: begin
               write_reg(REG_MATCH_RADIUS, MATCH_RADIUS_RESET);
               write_reg(REG_PILEUP_RADIUS, PILEUP_RADIUS_RESET);
            end
            2: begin
               write_reg(REG_MATCH_RADIUS, '0);
               write_reg(REG_PILEUP_RADIUS, '0);
            end
            3: begin
               write_reg(REG_MATCH_RADIUS, DIST_SAT);
               write_reg(REG_PILEUP_RADIUS, DIST_SAT);
            end
            default: begin
               write_reg(REG_MATCH_RADIUS, rand_radius());
               write_reg(REG_PILEUP_RADIUS, rand_radius());
            end
         endcase
         queue_random_phase(250);
      end

      // let any stray result surface before judging
      wait_drained();
      repeat (80) @(posedge clock);
      if (mismatch_count == 0)
         $display("greedy_jet_cone_matcher: match");
      else
         $display("greedy_jet_cone_matcher: mismatch");
      $finish;
   end

endmodule

[filelist.f]
rtl/gjcm_pkg.sv
rtl/gjcm_ram.sv
rtl/greedy_jet_cone_matcher.sv
test/tb_top.sv
